### rtl/core/pwmsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmsw_pkg
// Shared types, codes and constants of the pwm setpoint watchdog controller.
// ----------------------------------------------------------------------------
package pwmsw_pkg;

    localparam int NCHAN     = 3;
    localparam int DUTY_W    = 10;
    localparam int IN_DUTY_W = 12;
    localparam int WDOG_W    = 16;
    localparam int PERIOD_W  = 20;
    localparam int IDLE_W    = 17;
    localparam int TICK_W    = 32;
    localparam int HI_W      = 20;
    localparam int PROD_W    = PERIOD_W + DUTY_W;
    localparam int CFG_W     = 20;

    // command codes
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_PING      = 3'd1;
    localparam logic [2:0] CMD_GET       = 3'd2;
    localparam logic [2:0] CMD_ENABLE    = 3'd3;
    localparam logic [2:0] CMD_DISABLE   = 3'd4;
    localparam logic [2:0] CMD_SET_ALL   = 3'd5;
    localparam logic [2:0] CMD_SET_CHAN  = 3'd6;
    localparam logic [2:0] CMD_SET_THREE = 3'd7;

    // reply codes
    localparam logic [2:0] RPL_NONE      = 3'd0;
    localparam logic [2:0] RPL_PONG      = 3'd1;
    localparam logic [2:0] RPL_STATUS    = 3'd2;
    localparam logic [2:0] RPL_ERR_THREE = 3'd3;
    localparam logic [2:0] RPL_ERR_SET   = 3'd4;

    // configuration register indexes
    localparam logic REG_WATCHDOG = 1'b0;
    localparam logic REG_PERIOD   = 1'b1;

    localparam logic [WDOG_W-1:0]   WDOG_RESET   = 16'd500;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd200000;
    localparam logic [10:0]         DUTY_MAX     = 11'd1000;
    localparam logic [IDLE_W-1:0]   IDLE_MAX     = 17'h1FFFF;

    // floor(x / 1000) = (x * RECIP) >> RECIP_SH for any x below 2**30
    localparam int          RECIP_SH = 40;
    localparam logic [30:0] RECIP    = 31'd1099511628;

    // result of one item, before the high time is known
    typedef struct packed {
        logic [2:0]                   reply;
        logic                         enabled;
        logic [NCHAN-1:0][DUTY_W-1:0] target;
        logic [NCHAN-1:0][DUTY_W-1:0] applied;
        logic [TICK_W-1:0]            tick_count;
    } t_result;

    // load enables of the high time stages
    typedef struct packed {
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

### rtl/core/pwmsw_cmd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmsw_cmd_core
// Command decode, watchdog, setpoint state and configuration registers.
// ----------------------------------------------------------------------------
module pwmsw_cmd_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [2:0]                        i_cmd,
    input  logic [2:0]                        i_channel_number,
    input  logic [pwmsw_pkg::IN_DUTY_W-1:0]   i_duty_a,
    input  logic [pwmsw_pkg::IN_DUTY_W-1:0]   i_duty_b,
    input  logic [pwmsw_pkg::IN_DUTY_W-1:0]   i_duty_c,
    input  logic                              i_is_unbind,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic [pwmsw_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic [pwmsw_pkg::PERIOD_W-1:0]    o_period,
    output pwmsw_pkg::t_result                o_result
);
    import pwmsw_pkg::*;

    logic                         r_enable;
    logic [NCHAN-1:0][DUTY_W-1:0] r_target;
    logic [NCHAN-1:0][DUTY_W-1:0] r_applied;
    logic [IDLE_W-1:0]            r_idle;
    logic [TICK_W-1:0]            r_tick;
    logic [WDOG_W-1:0]            r_wdog;
    logic [PERIOD_W-1:0]          r_period;

    logic                         n_enable;
    logic [NCHAN-1:0][DUTY_W-1:0] n_target;
    logic [NCHAN-1:0][DUTY_W-1:0] n_applied;
    logic [IDLE_W-1:0]            n_idle;
    logic [TICK_W-1:0]            n_tick;
    logic [2:0]                   n_reply;

    logic ok_a;
    logic ok_b;
    logic ok_c;
    logic chan_ok;

    // duty range 0..1000 and channel range 1..3
    assign ok_a    = !i_duty_a[IN_DUTY_W-1] && (i_duty_a[10:0] <= DUTY_MAX);
    assign ok_b    = !i_duty_b[IN_DUTY_W-1] && (i_duty_b[10:0] <= DUTY_MAX);
    assign ok_c    = !i_duty_c[IN_DUTY_W-1] && (i_duty_c[10:0] <= DUTY_MAX);
    assign chan_ok = (i_channel_number >= 3'd1) && (i_channel_number <= 3'd3);

    // next state for one item
    always_comb begin
        n_enable  = r_enable;
        n_target  = r_target;
        n_applied = r_applied;
        n_idle    = r_idle;
        n_tick    = r_tick;
        n_reply   = RPL_NONE;
        if (i_cmd == CMD_TICK) begin
            if (r_idle != IDLE_MAX) begin
                n_idle = r_idle + 1'b1;
            end
            // watchdog trip
            if (r_enable && (n_idle > {1'b0, r_wdog})) begin
                n_enable = 1'b0;
                n_target = '0;
            end
            n_applied = n_enable ? n_target : '0;
            n_tick    = r_tick + 1'b1;
        end else if ((i_cmd == CMD_DISABLE) && i_is_unbind) begin
            n_enable = 1'b0;
            n_target = '0;
        end else begin
            n_idle = '0;
            case (i_cmd)
                CMD_PING: begin
                    n_reply = RPL_PONG;
                end
                CMD_GET: begin
                    n_reply = RPL_STATUS;
                end
                CMD_ENABLE: begin
                    n_enable = 1'b1;
                    n_reply  = RPL_STATUS;
                end
                CMD_DISABLE: begin
                    n_enable = 1'b0;
                    n_target = '0;
                    n_reply  = RPL_STATUS;
                end
                CMD_SET_ALL: begin
                    if (ok_a) begin
                        n_target = {NCHAN{i_duty_a[DUTY_W-1:0]}};
                        n_reply  = RPL_STATUS;
                    end else begin
                        n_reply = RPL_ERR_SET;
                    end
                end
                CMD_SET_CHAN: begin
                    if (chan_ok && ok_a) begin
                        n_target[i_channel_number[1:0] - 2'd1] = i_duty_a[DUTY_W-1:0];
                        n_reply = RPL_STATUS;
                    end else begin
                        n_reply = RPL_ERR_SET;
                    end
                end
                CMD_SET_THREE: begin
                    if (ok_a && ok_b && ok_c) begin
                        n_target[0] = i_duty_a[DUTY_W-1:0];
                        n_target[1] = i_duty_b[DUTY_W-1:0];
                        n_target[2] = i_duty_c[DUTY_W-1:0];
                        n_reply     = RPL_STATUS;
                    end else begin
                        n_reply = RPL_ERR_THREE;
                    end
                end
                default: begin
                    n_reply = RPL_NONE;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_target  <= '0;
            r_applied <= '0;
            r_idle    <= '0;
            r_tick    <= '0;
        end else if (i_fire) begin
            r_enable  <= n_enable;
            r_target  <= n_target;
            r_applied <= n_applied;
            r_idle    <= n_idle;
            r_tick    <= n_tick;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wdog   <= WDOG_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_WATCHDOG) begin
                r_wdog <= i_cfg_wdata[WDOG_W-1:0];
            end else begin
                r_period <= i_cfg_wdata[PERIOD_W-1:0];
            end
        end
    end

    assign o_period            = r_period;
    assign o_result.reply      = n_reply;
    assign o_result.enabled    = n_enable;
    assign o_result.target     = n_target;
    assign o_result.applied    = n_applied;
    assign o_result.tick_count = n_tick;

endmodule

### rtl/core/pwmsw_hi_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmsw_hi_time
// Two-stage high time unit: period times duty, then divide by 1000.
// ----------------------------------------------------------------------------
module pwmsw_hi_time (
    input  logic                            i_clk,
    input  pwmsw_pkg::t_pipe_ctl            i_ctl,
    input  logic [pwmsw_pkg::DUTY_W-1:0]    i_applied,
    input  logic [pwmsw_pkg::PERIOD_W-1:0]  i_period,
    output logic [pwmsw_pkg::HI_W-1:0]      o_high_ns
);
    import pwmsw_pkg::*;

    logic [PROD_W-1:0]      r_prod;
    logic [HI_W-1:0]        r_high;
    logic [PROD_W+30:0]     quot_full;

    // stage 2: period times permille
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_prod <= {{DUTY_W{1'b0}}, i_period} * {{PERIOD_W{1'b0}}, i_applied};
        end
    end

    // stage 3: divide by 1000 through the reciprocal
    assign quot_full = {31'd0, r_prod} * {{PROD_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_high <= quot_full[RECIP_SH +: HI_W];
        end
    end

    assign o_high_ns = r_high;

endmodule

### rtl/core/pwm_setpoint_watchdog_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_setpoint_watchdog_controller_core
// Three-channel pwm setpoint controller with command watchdog.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; a three-stage pipeline that stalls as a
//   whole only when all stages are full and the output is not taken
// reset: synchronous active low; clears state, counters and pipeline valids,
//   loads watchdog 500 and period 200000 ns
module pwm_setpoint_watchdog_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave item channel
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // channel_number[2:0], duty_a[14:3], duty_b[26:15], duty_c[38:27], zero[39]
    input  logic [39:0]                    i_s_axis_tdata,
    // cmd[2:0], is_unbind[3]
    input  logic [3:0]                     i_s_axis_tuser,
    // master result channel
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // enabled_now[0], target_one..three[30:1], applied_one..three[60:31],
    // high_ns_one..three[120:61], tick_count[152:121], zero[159:153]
    output logic [159:0]                   o_m_axis_tdata,
    // reply_kind[2:0]
    output logic [2:0]                     o_m_axis_tuser,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [pwmsw_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import pwmsw_pkg::*;

    logic                s_fire;
    logic                ld1;
    t_pipe_ctl           ctl;
    t_result             n_res;
    t_result             r_s1;
    t_result             r_s2;
    t_result             r_s3;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic [PERIOD_W-1:0] period;
    logic [NCHAN-1:0][HI_W-1:0] high_ns;

    // stage load enables
    assign ctl.ld3        = !r_v3 || i_m_axis_tready;
    assign ctl.ld2        = !r_v2 || ctl.ld3;
    assign ld1            = !r_v1 || ctl.ld2;
    assign o_s_axis_tready = ld1;
    assign s_fire         = i_s_axis_tvalid && ld1;

    pwmsw_cmd_core u_cmd (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (s_fire),
        .i_cmd            (i_s_axis_tuser[2:0]),
        .i_channel_number (i_s_axis_tdata[2:0]),
        .i_duty_a         (i_s_axis_tdata[14:3]),
        .i_duty_b         (i_s_axis_tdata[26:15]),
        .i_duty_c         (i_s_axis_tdata[38:27]),
        .i_is_unbind      (i_s_axis_tuser[3]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_period         (period),
        .o_result         (n_res)
    );

    // high time per channel
    for (genvar g = 0; g < NCHAN; g++) begin : g_hi
        pwmsw_hi_time u_hi (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_applied (r_s1.applied[g]),
            .i_period  (period),
            .o_high_ns (high_ns[g])
        );
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (ctl.ld2) begin
                r_v2 <= r_v1;
            end
            if (ctl.ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // result payload stages
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1 <= n_res;
        end
        if (ctl.ld2) begin
            r_s2 <= r_s1;
        end
        if (ctl.ld3) begin
            r_s3 <= r_s2;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tuser  = r_s3.reply;
    assign o_m_axis_tdata  = {7'd0, r_s3.tick_count,
                              high_ns[2], high_ns[1], high_ns[0],
                              r_s3.applied[2], r_s3.applied[1], r_s3.applied[0],
                              r_s3.target[2], r_s3.target[1], r_s3.target[0],
                              r_s3.enabled};

    // a tick leaves no applied duty while disabled
    a_tick_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_axis_tuser[2:0] == CMD_TICK)
        |=> (r_s1.enabled || r_s1.applied == '0))
        else $error("applied duty nonzero after tick while disabled");

    // a tick never gives a reply
    a_tick_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_axis_tuser[2:0] == CMD_TICK) |=> (r_s1.reply == RPL_NONE))
        else $error("tick produced a reply");

    // targets on the output stay within 0..1000
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_s3.target[0] <= DUTY_MAX[DUTY_W-1:0]
                          && r_s3.target[1] <= DUTY_MAX[DUTY_W-1:0]
                          && r_s3.target[2] <= DUTY_MAX[DUTY_W-1:0]))
        else $error("target out of range");

    // input stalls only with the whole pipeline full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && !i_m_axis_tready))
        else $error("input stalled with room in pipeline");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pwm setpoint watchdog controller core. Items are
// sent on the slave stream with random gaps, and results are taken with
// random back-pressure. Every accepted item runs through a local model of the
// controller, and each result is compared field by field with the oldest
// prediction. Directed tests cover duty and channel limits, enable, disable,
// unbind, the watchdog and the period extremes; random phases follow under
// several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    import pwmsw_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_PAUSE = 6;

    // expected content of one result item
    typedef struct packed {
        logic [2:0]                    reply;
        logic                          enabled;
        logic [NCHAN-1:0][DUTY_W-1:0]  target;
        logic [NCHAN-1:0][DUTY_W-1:0]  applied;
        logic [NCHAN-1:0][HI_W-1:0]    high_ns;
        logic [TICK_W-1:0]             tick_count;
    } t_pwm_status;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_valid   = 1'b0;
    logic [39:0]        s_data    = '0;
    logic [3:0]         s_user    = '0;
    logic               m_ready   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_addr  = REG_WATCHDOG;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    wire                s_ready;
    wire                m_valid;
    wire [159:0]        m_data;
    wire [2:0]          m_user;

    // local copy of the controller state and its registers
    logic                          ctl_enabled;
    logic [NCHAN-1:0][DUTY_W-1:0]  ctl_target;
    logic [NCHAN-1:0][DUTY_W-1:0]  ctl_applied;
    logic [IDLE_W-1:0]             ctl_idle;
    logic [TICK_W-1:0]             ctl_ticks;
    logic [WDOG_W-1:0]             ctl_wdog;
    logic [PERIOD_W-1:0]           ctl_period;

    t_pwm_status expected_status_q[$];
    int          errors = 0;
    bit          idling_on = 1'b1;
    int          random_items = 0;

    pwm_setpoint_watchdog_controller_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // controller model
    // ------------------------------------------------------------------
    function automatic bit duty_in_range(input int d);
        return d >= 0 && d <= int'(DUTY_MAX);
    endfunction

    task automatic force_safe();
        ctl_enabled = 1'b0;
        ctl_target  = '0;
    endtask

    task automatic model_reset();
        ctl_enabled = 1'b0;
        ctl_target  = '0;
        ctl_applied = '0;
        ctl_idle    = '0;
        ctl_ticks   = '0;
        ctl_wdog    = WDOG_RESET;
        ctl_period  = PERIOD_RESET;
    endtask

    // apply one item to the model and queue the status it should produce
    task automatic advance_controller(input logic [2:0] cmd, input logic [2:0] chan,
                                      input logic signed [11:0] da,
                                      input logic signed [11:0] db,
                                      input logic signed [11:0] dc, input logic unb);
        t_pwm_status      st;
        int               a;
        int               b;
        int               c;
        logic [2:0]       reply;
        longint unsigned  prod;
        a     = da;
        b     = db;
        c     = dc;
        reply = RPL_NONE;
        if (cmd == CMD_TICK) begin
            if (ctl_idle != IDLE_MAX)
                ctl_idle = ctl_idle + 1'b1;
            if (ctl_enabled && ctl_idle > ctl_wdog)
                force_safe();
            for (int i = 0; i < NCHAN; i++)
                ctl_applied[i] = ctl_enabled ? ctl_target[i] : '0;
            ctl_ticks = ctl_ticks + 1'b1;
        end else if (cmd == CMD_DISABLE && unb) begin
            // unbind keeps the idle count
            force_safe();
        end else begin
            ctl_idle = '0;
            case (cmd)
                CMD_PING: reply = RPL_PONG;
                CMD_GET: reply = RPL_STATUS;
                CMD_ENABLE: begin
                    ctl_enabled = 1'b1;
                    reply       = RPL_STATUS;
                end
                CMD_DISABLE: begin
                    force_safe();
                    reply = RPL_STATUS;
                end
                CMD_SET_ALL: begin
                    if (duty_in_range(a)) begin
                        for (int i = 0; i < NCHAN; i++)
                            ctl_target[i] = a[DUTY_W-1:0];
                        reply = RPL_STATUS;
                    end else begin
                        reply = RPL_ERR_SET;
                    end
                end
                CMD_SET_CHAN: begin
                    if (chan >= 1 && chan <= NCHAN && duty_in_range(a)) begin
                        ctl_target[chan-1] = a[DUTY_W-1:0];
                        reply              = RPL_STATUS;
                    end else begin
                        reply = RPL_ERR_SET;
                    end
                end
                default: begin
                    if (duty_in_range(a) && duty_in_range(b) && duty_in_range(c)) begin
                        ctl_target[0] = a[DUTY_W-1:0];
                        ctl_target[1] = b[DUTY_W-1:0];
                        ctl_target[2] = c[DUTY_W-1:0];
                        reply         = RPL_STATUS;
                    end else begin
                        reply = RPL_ERR_THREE;
                    end
                end
            endcase
        end
        st.reply      = reply;
        st.enabled    = ctl_enabled;
        st.target     = ctl_target;
        st.applied    = ctl_applied;
        st.tick_count = ctl_ticks;
        for (int i = 0; i < NCHAN; i++) begin
            prod          = longint'(ctl_period) * longint'(ctl_applied[i]);
            prod          = prod / 1000;
            st.high_ns[i] = prod[HI_W-1:0];
        end
        expected_status_q.push_back(st);
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] cmd, input logic [2:0] chan,
                             input logic [11:0] da, input logic [11:0] db,
                             input logic [11:0] dc, input logic unb);
        int gap;
        gap = (idling_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, dc, db, da, chan};
        s_user  <= {unb, cmd};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        advance_controller(cmd, chan, da, db, dc, unb);
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_item(cmd, 3'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    endtask

    // stop sending and wait for every pending result
    task automatic hold_until_drained();
        @(negedge clk);
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_register(input logic addr, input logic [CFG_W-1:0] value);
        hold_until_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == REG_WATCHDOG)
            ctl_wdog = value[WDOG_W-1:0];
        else
            ctl_period = value[PERIOD_W-1:0];
    endtask

    // mostly legal duties, some at the edges, some anywhere in 12 bits
    function automatic logic [11:0] pick_duty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 12'($urandom_range(0, 1000));
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return 12'd0;
                1: return 12'd1000;
                2: return 12'hFFF;
                default: return 12'd1001;
            endcase
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic send_random_item();
        int          r;
        logic [2:0]  cmd;
        logic [2:0]  chan;
        r    = $urandom_range(0, 99);
        chan = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, 3))
                                           : 3'($urandom_range(0, 7));
        if (r < 40)      cmd = CMD_TICK;
        else if (r < 48) cmd = CMD_ENABLE;
        else if (r < 54) cmd = CMD_DISABLE;
        else if (r < 58) cmd = CMD_PING;
        else if (r < 62) cmd = CMD_GET;
        else if (r < 74) cmd = CMD_SET_ALL;
        else if (r < 86) cmd = CMD_SET_CHAN;
        else             cmd = CMD_SET_THREE;
        send_item(cmd, chan, pick_duty(), pick_duty(), pick_duty(), 1'($urandom_range(0, 1)));
        random_items++;
        // a run of ticks lets the watchdog run out
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 48)) begin
                send_item(CMD_TICK, 3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                          1'($urandom_range(0, 1)));
                random_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_status_after_reset();
        send_cmd(CMD_GET);
        send_cmd(CMD_PING);
        send_cmd(CMD_TICK);
    endtask

    task automatic test_duty_limits();
        send_item(CMD_SET_ALL, 3'd0, 12'd1000, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_ALL, 3'd0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_ALL, 3'd0, 12'hFFF, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_ALL, 3'd0, 12'd1001, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_ALL, 3'd0, 12'h800, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_ALL, 3'd0, 12'h7FF, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_THREE, 3'd0, 12'd1000, 12'd0, 12'd500, 1'b0);
        send_item(CMD_SET_THREE, 3'd0, 12'hFFF, 12'd10, 12'd20, 1'b0);
        send_item(CMD_SET_THREE, 3'd0, 12'd10, 12'd1001, 12'd20, 1'b0);
        send_item(CMD_SET_THREE, 3'd0, 12'd10, 12'd20, 12'h7FF, 1'b0);
    endtask

    task automatic test_channel_select();
        send_item(CMD_SET_CHAN, 3'd0, 12'd100, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_CHAN, 3'd1, 12'd111, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_CHAN, 3'd2, 12'd222, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_CHAN, 3'd3, 12'd1000, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_CHAN, 3'd4, 12'd333, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_CHAN, 3'd7, 12'd444, 12'd0, 12'd0, 1'b0);
        send_item(CMD_SET_CHAN, 3'd2, 12'd1001, 12'd0, 12'd0, 1'b0);
    endtask

    task automatic test_enable_and_unbind();
        send_cmd(CMD_ENABLE);
        send_cmd(CMD_TICK);
        send_item(CMD_DISABLE, 3'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        send_cmd(CMD_TICK);
        send_cmd(CMD_ENABLE);
        send_item(CMD_SET_ALL, 3'd0, 12'd700, 12'd0, 12'd0, 1'b0);
        send_cmd(CMD_TICK);
        send_cmd(CMD_DISABLE);
        send_cmd(CMD_TICK);
        send_cmd(CMD_ENABLE);
        // the unbind flag means nothing outside a disable
        send_item(CMD_PING, 3'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        send_item(CMD_SET_ALL, 3'd0, 12'd900, 12'd0, 12'd0, 1'b1);
        send_cmd(CMD_TICK);
    endtask

    task automatic test_watchdog_timeout();
        // a zero limit stops an enabled block on its first tick
        write_register(REG_WATCHDOG, 20'd0);
        send_cmd(CMD_ENABLE);
        send_item(CMD_SET_ALL, 3'd0, 12'd300, 12'd0, 12'd0, 1'b0);
        send_cmd(CMD_TICK);
        write_register(REG_WATCHDOG, 20'd3);
        send_cmd(CMD_ENABLE);
        send_item(CMD_SET_THREE, 3'd0, 12'd5, 12'd500, 12'd995, 1'b0);
        repeat (5) send_cmd(CMD_TICK);
        // unbind leaves the idle count running
        send_cmd(CMD_ENABLE);
        send_cmd(CMD_TICK);
        send_item(CMD_DISABLE, 3'd0, 12'd0, 12'd0, 12'd0, 1'b1);
        repeat (4) send_cmd(CMD_TICK);
    endtask

    task automatic test_period_extremes();
        write_register(REG_WATCHDOG, 20'd65535);
        write_register(REG_PERIOD, 20'd0);
        send_cmd(CMD_ENABLE);
        send_item(CMD_SET_THREE, 3'd0, 12'd1000, 12'd1, 12'd999, 1'b0);
        send_cmd(CMD_TICK);
        write_register(REG_PERIOD, 20'd1);
        send_cmd(CMD_TICK);
        write_register(REG_PERIOD, 20'd1000000);
        send_cmd(CMD_TICK);
        write_register(REG_PERIOD, 20'd999999);
        send_cmd(CMD_TICK);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] wdog;
        logic [CFG_W-1:0] period;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: wdog = 20'd0;
                1: wdog = 20'($urandom_range(1, 8));
                2: wdog = 20'd65535;
                3: wdog = 20'($urandom_range(0, 65535));
                default: wdog = 20'($urandom_range(2, 30));
            endcase
            case (phase % 3)
                0: period = 20'd1000000;
                1: period = 20'd1;
                default: period = 20'($urandom_range(1, 1000000));
            endcase
            write_register(REG_WATCHDOG, wdog);
            write_register(REG_PERIOD, period);
            while (random_items < (phase + 1) * 100)
                send_random_item();
        end
    endtask

    // back-to-back items with no gaps and no back-pressure
    task automatic test_final_burst();
        idling_on = 1'b0;
        write_register(REG_WATCHDOG, 20'($urandom_range(1, 20)));
        write_register(REG_PERIOD, 20'($urandom_range(1, 1000000)));
        repeat (60) send_random_item();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    // receiver back-pressure in random bursts
    always @(negedge clk) begin
        int stall_left;
        if (!idling_on) begin
            m_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endfunction

    // compare each result item with the oldest prediction
    always @(posedge clk) begin
        t_pwm_status exp_s;
        if (rst_n && m_valid && m_ready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: result with nothing expected: tdata %h tuser %h", $time,
                         m_data, m_user);
                errors++;
            end else begin
                exp_s = expected_status_q.pop_front();
                check_field("reply_kind", exp_s.reply, m_user);
                check_field("enabled_now", exp_s.enabled, m_data[0]);
                for (int i = 0; i < NCHAN; i++) begin
                    check_field($sformatf("target_%0d", i + 1), exp_s.target[i],
                                m_data[1 + DUTY_W*i +: DUTY_W]);
                    check_field($sformatf("applied_%0d", i + 1), exp_s.applied[i],
                                m_data[31 + DUTY_W*i +: DUTY_W]);
                    check_field($sformatf("high_ns_%0d", i + 1), exp_s.high_ns[i],
                                m_data[61 + HI_W*i +: HI_W]);
                end
                check_field("tick_count", exp_s.tick_count, m_data[121 +: TICK_W]);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        int quiet_cycles;
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_status_after_reset();
        test_duty_limits();
        test_channel_select();
        test_enable_and_unbind();
        test_watchdog_timeout();
        test_period_extremes();
        test_random_traffic();
        test_final_burst();
        hold_until_drained();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
